// ----- rtl/lchr_pkg.sv -----
// Package for the light color hold reviser: sizes, color codes, register
// indexes, reset values, in and out transaction structs, config struct.
// No dependencies.
package lchr_pkg;

    localparam int CLEAR_LIMIT = 10;
    localparam int TABLE_DEPTH = CLEAR_LIMIT + 1;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W    = 32;
    localparam int COLOR_W = 3;
    localparam int TIME_W  = 48;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;

    localparam logic [COLOR_W-1:0] COLOR_UNKNOWN = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED     = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_GREEN   = 3'd2;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW  = 3'd3;
    localparam logic [COLOR_W-1:0] COLOR_BLACK   = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_WINDOW = 2'd1;

    localparam logic              ENABLE_RESET       = 1'b1;
    localparam logic [TIME_W-1:0] BLINK_WINDOW_RESET = 48'd1500000;

    typedef struct packed {
        logic [ID_W-1:0]    light_id;
        logic [COLOR_W-1:0] light_color;
        logic [TIME_W-1:0]  frame_time;
    } lchr_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] revised_color;
        logic               was_revised;
    } lchr_out_t;

    typedef struct packed {
        logic              enable;
        logic [TIME_W-1:0] blink_window;
    } lchr_cfg_t;

endpackage

// ----- rtl/lchr_table.sv -----
// Light table with parallel lookup, color revision and in-place update.
// Depends on lchr_pkg.
module lchr_table
    import lchr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  lchr_in_t  item,
    input  lchr_cfg_t cfg,
    output lchr_out_t result
);

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic [ID_W-1:0]        id_reg    [TABLE_DEPTH];
    logic [COLOR_W-1:0]     color_reg [TABLE_DEPTH];
    logic [TIME_W-1:0]      time_reg  [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] match;
    logic                   hit;
    logic [SLOT_W-1:0]      hit_slot;
    logic [COLOR_W-1:0]     hit_color;
    logic [TIME_W-1:0]      hit_time;
    logic                   time_nz;
    logic                   is_red_green;
    logic                   is_yellow;
    logic                   is_dark;
    logic                   yellow_hold;
    logic                   do_store;
    logic                   table_full;
    logic [TIME_W-1:0]      elapsed;
    logic                   in_window;
    logic [COLOR_W-1:0]     color_out;
    logic [SLOT_W-1:0]      wr_slot;
    logic                   wr_id;
    logic                   wr_color;
    logic                   wr_time;

    always_comb
    begin
        hit_slot  = '0;
        hit_color = '0;
        hit_time  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match[i] = valid_reg[i] && (id_reg[i] == item.light_id);
        end
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_slot  = SLOT_W'(i);
                hit_color = color_reg[i];
                hit_time  = time_reg[i];
            end
        end
    end

    assign hit          = |match;
    assign time_nz      = item.frame_time != '0;
    assign is_red_green = (item.light_color == COLOR_RED) || (item.light_color == COLOR_GREEN);
    assign is_yellow    = item.light_color == COLOR_YELLOW;
    assign is_dark      = !is_red_green && !is_yellow;
    assign yellow_hold  = is_yellow && hit && time_nz && (hit_color == COLOR_RED);
    assign do_store     = is_red_green || (is_yellow && !yellow_hold);
    assign table_full   = count_reg > COUNT_W'(CLEAR_LIMIT);
    assign elapsed      = item.frame_time - hit_time;
    assign in_window    = (item.frame_time < hit_time) || (elapsed < cfg.blink_window);

    always_comb
    begin
        color_out = item.light_color;
        if (cfg.enable)
        begin
            priority if (yellow_hold)
                color_out = COLOR_RED;
            else if (is_dark && hit && time_nz && in_window)
                color_out = hit_color;
            else
                color_out = item.light_color;
        end
    end

    assign result.revised_color = color_out;
    assign result.was_revised   = color_out != item.light_color;

    // Pick the entry to write and the next occupancy.
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        wr_slot    = hit_slot;
        wr_id      = 1'b0;
        wr_color   = 1'b0;
        wr_time    = 1'b0;
        if (fire && cfg.enable)
        begin
            if (yellow_hold)
            begin
                wr_time = 1'b1;
            end
            else if (do_store)
            begin
                wr_color = 1'b1;
                wr_time  = 1'b1;
                priority if (table_full)
                begin
                    valid_next    = '0;
                    valid_next[0] = 1'b1;
                    count_next    = COUNT_W'(1);
                    wr_slot       = '0;
                    wr_id         = 1'b1;
                end
                else if (!hit)
                begin
                    wr_slot             = count_reg[SLOT_W-1:0];
                    valid_next[wr_slot] = 1'b1;
                    count_next          = count_reg + COUNT_W'(1);
                    wr_id               = 1'b1;
                end
                else
                begin
                    wr_slot = hit_slot;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (wr_slot == SLOT_W'(i))
            begin
                if (wr_id)
                    id_reg[i] <= item.light_id;
                if (wr_color)
                    color_reg[i] <= item.light_color;
                if (wr_time)
                    time_reg[i] <= item.frame_time;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("table count disagrees with valid entries");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("light id present in more than one entry");

    a_disabled_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !cfg.enable) |=> ($stable(valid_reg) && $stable(count_reg)))
        else $error("table changed while disabled");

endmodule

// ----- rtl/light_color_hold_reviser.sv -----
// Top level of the light color hold reviser: channels, configuration
// registers, input and result registers. Depends on lchr_pkg, lchr_table.
//
//  channel | direction | payload    | transaction when
//  in      | to block  | lchr_in_t  | in_valid && in_ready
//  out     | from block| lchr_out_t | out_valid && out_ready
//  cfg     | to block  | index,data | cfg_valid && cfg_ready
//
// One detected light per cycle while the output is not stalled; a result
// passes the input register, then the result register, before it is valid.
// Table lookup and update finish between the two registers, so each light
// sees the table as left by the one before it.
// Reset empties the table, sets enable to 1 and the window to 1500000 us.
// A stalled output holds the result register; in_ready drops only when
// both registers are full and the output is stalled. cfg_ready is always high.
module light_color_hold_reviser
    import lchr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lchr_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lchr_out_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic      stage_valid_reg;
    lchr_in_t  stage_item_reg;
    logic      out_valid_reg;
    lchr_out_t out_data_reg;
    lchr_cfg_t cfg_reg;
    lchr_out_t result;
    logic      advance;
    logic      in_fire;

    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= ENABLE_RESET;
            cfg_reg.blink_window <= BLINK_WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ENABLE)
                cfg_reg.enable <= cfg_data[0];
            else if (cfg_index == REG_BLINK_WINDOW)
                cfg_reg.blink_window <= cfg_data[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            stage_item_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    lchr_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (stage_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result register overwritten while stalled");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_item_reg)))
        else $error("input register lost a pending light");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for light_color_hold_reviser: a directed table, then random lights in phases of
// configuration, checked in order against the typed results of the table or a color table predictor.
// Depends on lchr_pkg and light_color_hold_reviser.
module tb_top;
    import lchr_pkg::*;

    localparam logic [COLOR_W-1:0] COLOR_SPARE_MIN = 3'd5;
    localparam logic [COLOR_W-1:0] COLOR_SPARE_MAX = 3'd7;
    localparam logic [TIME_W-1:0]  TIME_MAX        = {TIME_W{1'b1}};
    localparam int                 PHASES          = 5;
    localparam int                 PHASE_ITEMS     = 310;
    localparam int                 IDLE_PCT        = 15;

    typedef struct packed {
        lchr_in_t  light;
        logic      typed;
        lchr_out_t result;
    } light_row_t;

    light_row_t directed_rows [25] = '{
        '{'{32'h0, COLOR_BLACK, 48'd100}, 1'b1, '{COLOR_BLACK, 1'b0}},
        '{'{32'h0, COLOR_RED, 48'd100}, 1'b1, '{COLOR_RED, 1'b0}},
        '{'{32'h0, COLOR_BLACK, 48'd200}, 1'b1, '{COLOR_RED, 1'b1}},
        '{'{32'h0, COLOR_UNKNOWN, 48'd0}, 1'b1, '{COLOR_UNKNOWN, 1'b0}},
        '{'{32'h0, COLOR_YELLOW, 48'd300}, 1'b1, '{COLOR_RED, 1'b1}},
        '{'{32'h0, COLOR_BLACK, 48'd1500299}, 1'b0, '0},
        '{'{32'h0, COLOR_BLACK, 48'd1500300}, 1'b0, '0},
        '{'{32'h0, COLOR_UNKNOWN, 48'd50}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, COLOR_GREEN, TIME_MAX}, 1'b1, '{COLOR_GREEN, 1'b0}},
        '{'{32'hFFFF_FFFF, COLOR_SPARE_MAX, TIME_MAX}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, COLOR_SPARE_MIN, 48'd1}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, COLOR_YELLOW, 48'd0}, 1'b1, '{COLOR_YELLOW, 1'b0}},
        '{'{32'h0, COLOR_YELLOW, 48'd0}, 1'b1, '{COLOR_YELLOW, 1'b0}},
        '{'{32'h0, COLOR_BLACK, 48'd10}, 1'b0, '0},
        '{'{32'h1, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h2, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h3, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h4, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h5, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h6, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h7, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h8, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h9, COLOR_RED, 48'd1000}, 1'b0, '0},
        '{'{32'h0, COLOR_GREEN, 48'd2000}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, COLOR_BLACK, 48'd5}, 1'b1, '{COLOR_BLACK, 1'b0}}
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    lchr_in_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    lchr_out_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ENABLE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    light_color_hold_reviser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    logic               cfg_enable = ENABLE_RESET;
    logic [TIME_W-1:0]  cfg_window = BLINK_WINDOW_RESET;
    logic               tbl_valid [TABLE_DEPTH] = '{default: 1'b0};
    logic [ID_W-1:0]    tbl_id    [TABLE_DEPTH];
    logic [COLOR_W-1:0] tbl_color [TABLE_DEPTH];
    logic [TIME_W-1:0]  tbl_time  [TABLE_DEPTH];
    int                 tbl_count = 0;

    lchr_out_t          pending_results [$];
    int                 mismatches = 0;
    bit                 steady = 1'b0;
    logic [ID_W-1:0]    id_pool [16];
    logic [TIME_W-1:0]  now_us = 48'd1;

    function automatic int find_entry(input logic [ID_W-1:0] id);
        int slot;
        slot = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl_id[i] == id)
                slot = i;
        return slot;
    endfunction

    function automatic void store_entry(input logic [ID_W-1:0] id,
                                        input logic [COLOR_W-1:0] color,
                                        input logic [TIME_W-1:0] t);
        int slot;
        if (tbl_count > CLEAR_LIMIT)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                tbl_valid[i] = 1'b0;
            tbl_count = 0;
        end
        slot = find_entry(id);
        if (slot < 0)
        begin
            slot = tbl_count;
            tbl_count++;
            tbl_valid[slot] = 1'b1;
            tbl_id[slot] = id;
        end
        tbl_color[slot] = color;
        tbl_time[slot] = t;
    endfunction

    function automatic lchr_out_t revise_light(input lchr_in_t light);
        lchr_out_t         res;
        int                slot;
        logic [TIME_W-1:0] st;
        res.revised_color = light.light_color;
        if (cfg_enable)
        begin
            slot = find_entry(light.light_id);
            if (light.light_color == COLOR_RED || light.light_color == COLOR_GREEN)
                store_entry(light.light_id, light.light_color, light.frame_time);
            else if (light.light_color == COLOR_YELLOW)
            begin
                if (slot >= 0 && light.frame_time != 0 && tbl_color[slot] == COLOR_RED)
                begin
                    res.revised_color = COLOR_RED;
                    tbl_time[slot] = light.frame_time;
                end
                else
                    store_entry(light.light_id, light.light_color, light.frame_time);
            end
            else if (slot >= 0 && light.frame_time != 0)
            begin
                st = tbl_time[slot];
                if (light.frame_time < st || (light.frame_time - st) < cfg_window)
                    res.revised_color = tbl_color[slot];
            end
        end
        res.was_revised = (res.revised_color != light.light_color);
        return res;
    endfunction

    function automatic lchr_in_t random_light();
        lchr_in_t    light;
        int          pick;
        int          slot;
        logic [63:0] wide;
        pick = $urandom_range(0, 99);
        light.light_id = (pick < 10) ? $urandom : id_pool[$urandom_range(0, 15)];
        pick = $urandom_range(0, 99);
        if (pick < 25)
            light.light_color = COLOR_RED;
        else if (pick < 40)
            light.light_color = COLOR_GREEN;
        else if (pick < 60)
            light.light_color = COLOR_YELLOW;
        else if (pick < 80)
            light.light_color = COLOR_BLACK;
        else if (pick < 90)
            light.light_color = COLOR_UNKNOWN;
        else
            light.light_color = COLOR_W'($urandom_range(COLOR_SPARE_MIN, COLOR_SPARE_MAX));
        now_us += TIME_W'($urandom_range(0, 600000));
        slot = find_entry(light.light_id);
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (pick < 5)
            light.frame_time = '0;
        else if (pick < 10)
            light.frame_time = wide[TIME_W-1:0];
        else if (slot >= 0 && pick < 35)
            light.frame_time = tbl_time[slot] + cfg_window - 1 + TIME_W'($urandom_range(0, 2));
        else if (slot >= 0 && pick < 40)
            light.frame_time = tbl_time[slot] - TIME_W'($urandom_range(1, 1000));
        else
            light.frame_time = now_us;
        return light;
    endfunction

    task automatic send_light(input lchr_in_t light, input logic typed,
                              input lchr_out_t typed_result);
        lchr_out_t predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= light;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = revise_light(light);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic set_config(input logic enable_bit, input logic [TIME_W-1:0] window);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ENABLE;
        cfg_data  <= CFG_DATA_W'(enable_bit);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_enable = enable_bit;
        cfg_index <= REG_BLINK_WINDOW;
        cfg_data  <= window;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_window = window;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        lchr_out_t want;
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transaction, color %0d revised %0d", $time,
                         out_data.revised_color, out_data.was_revised);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.revised_color !== want.revised_color)
                begin
                    mismatches++;
                    $display("%0t: revised_color expected %0d got %0d", $time,
                             want.revised_color, out_data.revised_color);
                end
                if (out_data.was_revised !== want.was_revised)
                begin
                    mismatches++;
                    $display("%0t: was_revised expected %0d got %0d", $time,
                             want.was_revised, out_data.was_revised);
                end
            end
        end
    end

    initial
    begin
        logic [TIME_W-1:0] window;
        logic              enable_bit;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i])
            send_light(directed_rows[i].light, directed_rows[i].typed,
                       directed_rows[i].result);
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            enable_bit = (p != 1);
            unique case (p)
                2:       window = '0;
                3:       window = TIME_MAX;
                4:       window = TIME_W'($urandom_range(1000, 3000000));
                default: window = BLINK_WINDOW_RESET;
            endcase
            set_config(enable_bit, window);
            foreach (id_pool[i])
                id_pool[i] = $urandom;
            id_pool[0] = '0;
            id_pool[1] = '1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                steady = (p == 3 && n < 250);
                send_light(random_light(), 1'b0, '0);
            end
            steady = 1'b0;
        end
        drain_results();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
